// File: rtl/core/rnag_pkg.sv
package rnag_pkg;

   // fixed-point fraction bits of the rotation factors (Q2.14)
   localparam int FRAC_BITS = 14;
   // source dimensions above this are clamped
   localparam int MAX_SRC_DIM = 2048;
   // register stages from request to response
   localparam int NUM_STAGES = 8;
   // bounding-box size saturation value
   localparam logic [12:0] DIM_SAT = 13'd8191;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_COS_FACTOR = 3'd0;
   localparam logic [2:0] CSR_SIN_FACTOR = 3'd1;
   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_CHANNELS   = 3'd4;

   // pipeline occupancy and per-stage load enables
   typedef struct packed {
      logic [NUM_STAGES-1:0] valid;
      logic [NUM_STAGES-1:0] load;
   } rnag_flow_type;

endpackage

// File: rtl/core/rnag_if.sv
interface rnag_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] dest_x;
   logic [11:0] dest_y;

   modport source (output valid, output dest_x, output dest_y, input ready);
   modport sink (input valid, input dest_x, input dest_y, output ready);
endinterface

interface rnag_rsp_if;
   logic        valid;
   logic        ready;
   logic        inside_res;
   logic [10:0] src_x;
   logic [10:0] src_y;
   logic [23:0] src_offset;
   logic [25:0] dest_offset;
   logic [12:0] dest_width;
   logic [12:0] dest_height;

   modport source (output valid, output inside_res, output src_x, output src_y,
                   output src_offset, output dest_offset, output dest_width,
                   output dest_height, input ready);
   modport sink (input valid, input inside_res, input src_x, input src_y,
                 input src_offset, input dest_offset, input dest_width,
                 input dest_height, output ready);
endinterface

// File: rtl/core/rnag_flow.sv
module rnag_flow
   import rnag_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          rsp_ready,
   output logic          req_ready,
   output rnag_flow_type flow
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // a stage loads when empty or when its content moves on; bubbles collapse
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // valid bits travel with the data
   always_comb begin
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready  = load[0];
   assign flow.valid = valid_ff;
   assign flow.load  = load;

endmodule

// File: rtl/core/rotate_nearest_address_gen.sv
// channel  | direction | payload
// req_ch   | in        | dest_x, dest_y
// rsp_ch   | out       | inside_res, src_x, src_y, src_offset, dest_offset,
//          |           | dest_width, dest_height
// csr_*    | in        | csr_we, csr_index, csr_wdata (write only)
//
// eight register stages, s1 to s8, lie between a request transfer and its response
// transfer; one item per cycle is sustained while the response side does not stall
// the stages break up the chain of multipliers, each followed by a register
// reset is synchronous, clears the stage valid bits and sets the configuration
// registers to their defaults; the data registers are not reset
// a stalled response holds its stage; empty stages behind it still fill
module rotate_nearest_address_gen
   import rnag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rnag_req_if.sink    req_ch,
   rnag_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic signed [15:0] cos_ff;
   logic signed [15:0] sin_ff;
   logic [11:0]        src_width_ff;
   logic [11:0]        src_height_ff;
   logic [2:0]         channels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff        <= 16'sd16384;
         sin_ff        <= 16'sd0;
         src_width_ff  <= 12'd1;
         src_height_ff <= 12'd1;
         channels_ff   <= 3'd4;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COS_FACTOR: cos_ff        <= csr_wdata;
            CSR_SIN_FACTOR: sin_ff        <= csr_wdata;
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[11:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[11:0];
            CSR_CHANNELS:   channels_ff   <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // clamped source size and factor magnitudes
   logic [11:0] w_clamp;
   logic [11:0] h_clamp;
   logic [15:0] abs_c;
   logic [15:0] abs_s;

   assign w_clamp = (src_width_ff > 12'(MAX_SRC_DIM)) ? 12'(MAX_SRC_DIM) : src_width_ff;
   assign h_clamp = (src_height_ff > 12'(MAX_SRC_DIM)) ? 12'(MAX_SRC_DIM) : src_height_ff;
   assign abs_c   = cos_ff[15] ? 16'(-cos_ff) : 16'(cos_ff);
   assign abs_s   = sin_ff[15] ? 16'(-sin_ff) : 16'(sin_ff);

   // pipeline control
   rnag_flow_type flow;

   rnag_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .req_ready (req_ch.ready),
      .flow      (flow)
   );

   // stage 1: bounding-box partial products
   logic [11:0] s1_dx_ff, s1_dy_ff;
   logic [26:0] s1_wc_ff, s1_ws_ff, s1_hc_ff, s1_hs_ff;

   always_ff @(posedge clock) begin
      if (flow.load[0]) begin
         s1_dx_ff <= req_ch.dest_x;
         s1_dy_ff <= req_ch.dest_y;
         s1_wc_ff <= 27'(w_clamp) * 27'(abs_c);
         s1_ws_ff <= 27'(w_clamp) * 27'(abs_s);
         s1_hc_ff <= 27'(h_clamp) * 27'(abs_c);
         s1_hs_ff <= 27'(h_clamp) * 27'(abs_s);
      end
   end

   // stage 2: ceiling and saturation of the box size
   logic [27:0] box_w_sum, box_h_sum;
   logic [13:0] box_w_raw, box_h_raw;
   logic [12:0] s2_dw_in, s2_dh_in;
   logic [12:0] s2_dw_ff, s2_dh_ff;
   logic [11:0] s2_dx_ff, s2_dy_ff;

   always_comb begin
      box_w_sum = 28'(s1_wc_ff) + 28'(s1_hs_ff) + 28'((2 ** FRAC_BITS) - 1);
      box_h_sum = 28'(s1_ws_ff) + 28'(s1_hc_ff) + 28'((2 ** FRAC_BITS) - 1);
      box_w_raw = 14'(box_w_sum >> FRAC_BITS);
      box_h_raw = 14'(box_h_sum >> FRAC_BITS);
      s2_dw_in  = (box_w_raw > 14'(DIM_SAT)) ? DIM_SAT : box_w_raw[12:0];
      s2_dh_in  = (box_h_raw > 14'(DIM_SAT)) ? DIM_SAT : box_h_raw[12:0];
   end

   always_ff @(posedge clock) begin
      if (flow.load[1]) begin
         s2_dx_ff <= s1_dx_ff;
         s2_dy_ff <= s1_dy_ff;
         s2_dw_ff <= s2_dw_in;
         s2_dh_ff <= s2_dh_in;
      end
   end

   // stage 3: centred coordinate in half pixels, destination row base
   logic signed [13:0] s3_xc2_ff, s3_yc2_ff;
   logic [24:0]        s3_drow_ff;
   logic [11:0]        s3_dx_ff;
   logic [12:0]        s3_dw_ff, s3_dh_ff;

   always_ff @(posedge clock) begin
      if (flow.load[2]) begin
         s3_xc2_ff  <= signed'({1'b0, s2_dx_ff, 1'b0}) - signed'({1'b0, s2_dw_ff});
         s3_yc2_ff  <= signed'({1'b0, s2_dy_ff, 1'b0}) - signed'({1'b0, s2_dh_ff});
         s3_drow_ff <= 25'(s2_dy_ff) * 25'(s2_dw_ff);
         s3_dx_ff   <= s2_dx_ff;
         s3_dw_ff   <= s2_dw_ff;
         s3_dh_ff   <= s2_dh_ff;
      end
   end

   // stage 4: inverse rotation products, destination linear index
   logic signed [29:0] s4_pxc_ff, s4_pys_ff, s4_pyc_ff, s4_pxs_ff;
   logic [25:0]        s4_dlin_ff;
   logic [12:0]        s4_dw_ff, s4_dh_ff;

   always_ff @(posedge clock) begin
      if (flow.load[3]) begin
         s4_pxc_ff  <= 30'(s3_xc2_ff) * 30'(cos_ff);
         s4_pys_ff  <= 30'(s3_yc2_ff) * 30'(sin_ff);
         s4_pyc_ff  <= 30'(s3_yc2_ff) * 30'(cos_ff);
         s4_pxs_ff  <= 30'(s3_xc2_ff) * 30'(sin_ff);
         s4_dlin_ff <= 26'(s3_drow_ff) + 26'(s3_dx_ff);
         s4_dw_ff   <= s3_dw_ff;
         s4_dh_ff   <= s3_dh_ff;
      end
   end

   // stage 5: source position sums, destination offset
   logic signed [31:0] w_shift, h_shift;
   logic signed [31:0] s5_xs_ff, s5_ys_ff;
   logic [25:0]        s5_doff_ff;
   logic [12:0]        s5_dw_ff, s5_dh_ff;

   assign w_shift = signed'(32'(w_clamp)) <<< FRAC_BITS;
   assign h_shift = signed'(32'(h_clamp)) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      if (flow.load[4]) begin
         s5_xs_ff   <= 32'(s4_pxc_ff) + 32'(s4_pys_ff) + w_shift;
         s5_ys_ff   <= 32'(s4_pyc_ff) - 32'(s4_pxs_ff) + h_shift;
         s5_doff_ff <= s4_dlin_ff * 26'(channels_ff);
         s5_dw_ff   <= s4_dw_ff;
         s5_dh_ff   <= s4_dh_ff;
      end
   end

   // stage 6: round half away from zero, bounds check
   logic signed [31:0] sx_full, sy_full;
   logic               inside_x, inside_y, s6_inside_in;
   logic               s6_inside_ff;
   logic [10:0]        s6_osx_ff, s6_osy_ff;
   logic [25:0]        s6_doff_ff;
   logic [12:0]        s6_dw_ff, s6_dh_ff;

   always_comb begin
      // a negative value takes half minus one, which rounds its magnitude up
      sx_full = (s5_xs_ff + 32'(2 ** FRAC_BITS) - signed'(32'(s5_xs_ff[31])))
                >>> (FRAC_BITS + 1);
      sy_full = (s5_ys_ff + 32'(2 ** FRAC_BITS) - signed'(32'(s5_ys_ff[31])))
                >>> (FRAC_BITS + 1);
      inside_x = !sx_full[31] && (sx_full[30:0] < 31'(w_clamp));
      inside_y = !sy_full[31] && (sy_full[30:0] < 31'(h_clamp));
      s6_inside_in = inside_x && inside_y;
   end

   always_ff @(posedge clock) begin
      if (flow.load[5]) begin
         s6_inside_ff <= s6_inside_in;
         s6_osx_ff    <= s6_inside_in ? sx_full[10:0] : 11'd0;
         s6_osy_ff    <= s6_inside_in ? sy_full[10:0] : 11'd0;
         s6_doff_ff   <= s5_doff_ff;
         s6_dw_ff     <= s5_dw_ff;
         s6_dh_ff     <= s5_dh_ff;
      end
   end

   // stage 7: source row base
   logic        s7_inside_ff;
   logic [10:0] s7_osx_ff, s7_osy_ff;
   logic [22:0] s7_srow_ff;
   logic [25:0] s7_doff_ff;
   logic [12:0] s7_dw_ff, s7_dh_ff;

   always_ff @(posedge clock) begin
      if (flow.load[6]) begin
         s7_inside_ff <= s6_inside_ff;
         s7_osx_ff    <= s6_osx_ff;
         s7_osy_ff    <= s6_osy_ff;
         s7_srow_ff   <= 23'(s6_osy_ff) * 23'(w_clamp);
         s7_doff_ff   <= s6_doff_ff;
         s7_dw_ff     <= s6_dw_ff;
         s7_dh_ff     <= s6_dh_ff;
      end
   end

   // stage 8: source byte offset, output register
   logic [22:0] src_lin;
   logic [25:0] src_scaled;
   logic        s8_inside_ff;
   logic [10:0] s8_osx_ff, s8_osy_ff;
   logic [23:0] s8_soff_ff;
   logic [25:0] s8_doff_ff;
   logic [12:0] s8_dw_ff, s8_dh_ff;

   assign src_lin    = s7_srow_ff + 23'(s7_osx_ff);
   assign src_scaled = 26'(src_lin) * 26'(channels_ff);

   always_ff @(posedge clock) begin
      if (flow.load[7]) begin
         s8_inside_ff <= s7_inside_ff;
         s8_osx_ff    <= s7_osx_ff;
         s8_osy_ff    <= s7_osy_ff;
         s8_soff_ff   <= src_scaled[23:0];
         s8_doff_ff   <= s7_doff_ff;
         s8_dw_ff     <= s7_dw_ff;
         s8_dh_ff     <= s7_dh_ff;
      end
   end

   // response channel
   assign rsp_ch.valid       = flow.valid[NUM_STAGES-1];
   assign rsp_ch.inside_res  = s8_inside_ff;
   assign rsp_ch.src_x       = s8_osx_ff;
   assign rsp_ch.src_y       = s8_osy_ff;
   assign rsp_ch.src_offset  = s8_soff_ff;
   assign rsp_ch.dest_offset = s8_doff_ff;
   assign rsp_ch.dest_width  = s8_dw_ff;
   assign rsp_ch.dest_height = s8_dh_ff;

endmodule

// File: rtl/core/rnag_checker.sv
module rnag_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_inside,
   input logic [10:0] rsp_src_x,
   input logic [10:0] rsp_src_y,
   input logic [23:0] rsp_src_offset,
   input logic [25:0] rsp_dest_offset
);

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response stays and keeps its offset
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_offset))
      else $error("stalled response dropped or changed");

   // an outside point reports zero coordinates and offset
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside |-> rsp_src_x == 11'd0 && rsp_src_y == 11'd0
                                   && rsp_src_offset == 24'd0)
      else $error("outside point with non-zero source fields");

   // with an empty output stage the pipeline always takes a request
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked while output stage is empty");

endmodule

bind rotate_nearest_address_gen rnag_checker u_rnag_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_inside      (rsp_ch.inside_res),
   .rsp_src_x       (rsp_ch.src_x),
   .rsp_src_y       (rsp_ch.src_y),
   .rsp_src_offset  (rsp_ch.src_offset),
   .rsp_dest_offset (rsp_ch.dest_offset)
);

// File: dv/rotation_map_checker.sv
`timescale 1ns / 1ps

module rotation_map_checker
   import rnag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rnag_req_if         req_ch,
   rnag_rsp_if         rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct packed {
      logic        inside_res;
      logic [10:0] src_x;
      logic [10:0] src_y;
      logic [23:0] src_offset;
      logic [25:0] dest_offset;
      logic [12:0] dest_width;
      logic [12:0] dest_height;
   } pixel_map_type;

   // shadow copy of the rotation registers
   logic [15:0] cos_q;
   logic [15:0] sin_q;
   logic [11:0] width_q;
   logic [11:0] height_q;
   logic [2:0]  chan_q;

   pixel_map_type expected_maps[$];
   int            failures = 0;

   // bounding-box edge: round up to whole pixels, then saturate
   function automatic longint ceil_box(longint v);
      longint r;
      r = (v + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS;
      return (r > longint'(DIM_SAT)) ? longint'(DIM_SAT) : r;
   endfunction

   // back to whole source pixels, halves rounded away from zero
   function automatic longint round_half_away(longint v);
      longint half;
      half = longint'(1) << FRAC_BITS;
      if (v >= 0)
         return (v + half) >>> (FRAC_BITS + 1);
      return -((-v + half) >>> (FRAC_BITS + 1));
   endfunction

   // inverse rotation of one destination pixel into source space
   function automatic pixel_map_type map_to_source(logic [11:0] dest_x, logic [11:0] dest_y);
      longint        c, s, w, h, ch, abs_c, abs_s, box_w, box_h;
      longint        xc2, yc2, sx, sy, soff, doff;
      logic          in_image;
      pixel_map_type m;
      c = longint'($signed(cos_q));
      s = longint'($signed(sin_q));
      w = (width_q > MAX_SRC_DIM) ? longint'(MAX_SRC_DIM) : longint'(width_q);
      h = (height_q > MAX_SRC_DIM) ? longint'(MAX_SRC_DIM) : longint'(height_q);
      ch = longint'(chan_q);
      abs_c = (c < 0) ? -c : c;
      abs_s = (s < 0) ? -s : s;
      box_w = ceil_box(w * abs_c + h * abs_s);
      box_h = ceil_box(w * abs_s + h * abs_c);
      // centred coordinate in half pixels
      xc2 = 2 * longint'(dest_x) - box_w;
      yc2 = 2 * longint'(dest_y) - box_h;
      sx = round_half_away(xc2 * c + yc2 * s + (w << FRAC_BITS));
      sy = round_half_away(yc2 * c - xc2 * s + (h << FRAC_BITS));
      in_image = (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
      m = '0;
      m.inside_res = in_image;
      if (in_image) begin
         soff = (sy * w + sx) * ch;
         m.src_x = sx[10:0];
         m.src_y = sy[10:0];
         m.src_offset = soff[23:0];
      end
      doff = (longint'(dest_y) * box_w + longint'(dest_x)) * ch;
      m.dest_offset = doff[25:0];
      m.dest_width = box_w[12:0];
      m.dest_height = box_h[12:0];
      return m;
   endfunction

   function automatic void note_failure(string what);
      failures++;
      if (failures <= 10)
         $display("%0t: rotation map mismatch: %s", $time, what);
   endfunction

   function automatic void compare_map(pixel_map_type want, pixel_map_type got);
      if (got.inside_res !== want.inside_res)
         note_failure($sformatf("inside_res expected %0d got %0d",
                                want.inside_res, got.inside_res));
      if (got.src_x !== want.src_x)
         note_failure($sformatf("src_x expected %0d got %0d", want.src_x, got.src_x));
      if (got.src_y !== want.src_y)
         note_failure($sformatf("src_y expected %0d got %0d", want.src_y, got.src_y));
      if (got.src_offset !== want.src_offset)
         note_failure($sformatf("src_offset expected %0d got %0d",
                                want.src_offset, got.src_offset));
      if (got.dest_offset !== want.dest_offset)
         note_failure($sformatf("dest_offset expected %0d got %0d",
                                want.dest_offset, got.dest_offset));
      if (got.dest_width !== want.dest_width)
         note_failure($sformatf("dest_width expected %0d got %0d",
                                want.dest_width, got.dest_width));
      if (got.dest_height !== want.dest_height)
         note_failure($sformatf("dest_height expected %0d got %0d",
                                want.dest_height, got.dest_height));
   endfunction

   // track register writes, predict on request transfers, check response transfers
   always @(posedge clock) begin : watch_channels
      pixel_map_type got_map;
      if (reset) begin
         cos_q = 16'd16384;
         sin_q = 16'd0;
         width_q = 12'd1;
         height_q = 12'd1;
         chan_q = 3'd4;
         expected_maps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COS_FACTOR: cos_q = csr_wdata;
               CSR_SIN_FACTOR: sin_q = csr_wdata;
               CSR_SRC_WIDTH:  width_q = csr_wdata[11:0];
               CSR_SRC_HEIGHT: height_q = csr_wdata[11:0];
               CSR_CHANNELS:   chan_q = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_maps.push_back(map_to_source(req_ch.dest_x, req_ch.dest_y));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_map.inside_res = rsp_ch.inside_res;
            got_map.src_x = rsp_ch.src_x;
            got_map.src_y = rsp_ch.src_y;
            got_map.src_offset = rsp_ch.src_offset;
            got_map.dest_offset = rsp_ch.dest_offset;
            got_map.dest_width = rsp_ch.dest_width;
            got_map.dest_height = rsp_ch.dest_height;
            if (expected_maps.size() == 0)
               note_failure("response transfer with nothing outstanding");
            else
               compare_map(expected_maps.pop_front(), got_map);
         end
      end
      mismatch_count <= failures;
      pending_count <= expected_maps.size();
   end

endmodule

// File: dv/rotate_nearest_address_gen_tb.sv
`timescale 1ns / 1ps

module rotate_nearest_address_gen_tb;
   import rnag_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BLOCKS  = 5;
   localparam int BLOCK_ITEMS    = 50;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int mismatch_count;
   int pending_count;
   int send_idle_pct;
   int recv_stall_pct;
   int dest_span;
   int quiet_cycles = 0;

   rnag_req_if req_ch();
   rnag_rsp_if rsp_ch();

   rotate_nearest_address_gen i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rotation_map_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 50 MHz clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rotate_nearest_address_gen_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic write_register(input logic [2:0] index, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_rotation(input logic [15:0] c, input logic [15:0] s,
                                   input logic [11:0] w, input logic [11:0] h,
                                   input logic [2:0] ch);
      write_register(CSR_COS_FACTOR, c);
      write_register(CSR_SIN_FACTOR, s);
      write_register(CSR_SRC_WIDTH, {4'd0, w});
      write_register(CSR_SRC_HEIGHT, {4'd0, h});
      write_register(CSR_CHANNELS, {13'd0, ch});
      csr_we <= 1'b0;
   endtask

   // one request transfer, with random idle cycles ahead of it
   task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.dest_x <= x;
      req_ch.dest_y <= y;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold off the sender until every response is back, then let the pipe settle
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (NUM_STAGES + 4) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_dimension();
      case ($urandom_range(9))
         0: return 12'($urandom);
         1: return 12'(MAX_SRC_DIM);
         default: return 12'($urandom_range(1, 40));
      endcase
   endfunction

   // mostly true rotation angles, sometimes arbitrary factor patterns
   task automatic random_rotation();
      real         angle;
      real         cr;
      real         sr;
      logic [15:0] c;
      logic [15:0] s;
      logic [11:0] w;
      logic [11:0] h;
      logic [2:0]  ch;
      int          wc;
      int          hc;
      angle = real'($urandom_range(359)) * 3.14159265358979 / 180.0;
      cr = 16384.0 * $cos(angle);
      sr = 16384.0 * $sin(angle);
      c = 16'((cr >= 0.0) ? $rtoi(cr + 0.5) : $rtoi(cr - 0.5));
      s = 16'((sr >= 0.0) ? $rtoi(sr + 0.5) : $rtoi(sr - 0.5));
      if ($urandom_range(4) == 0) begin
         c = 16'($urandom);
         s = 16'($urandom);
      end
      w = pick_dimension();
      h = pick_dimension();
      ch = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
      program_rotation(c, s, w, h, ch);
      wc = (w > MAX_SRC_DIM) ? MAX_SRC_DIM : int'(w);
      hc = (h > MAX_SRC_DIM) ? MAX_SRC_DIM : int'(h);
      dest_span = (wc + hc + 2 > 4095) ? 4095 : wc + hc + 2;
   endtask

   initial begin : stimulus
      logic [11:0] x;
      logic [11:0] y;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_COS_FACTOR;
      csr_wdata = 16'd0;
      req_ch.valid = 1'b0;
      req_ch.dest_x = 12'd0;
      req_ch.dest_y = 12'd0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 30;
      recv_stall_pct = 60;
      dest_span = 4095;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // identity on a one-pixel source straight after reset
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd4095, 12'd4095);

      // quarter turn on a small frame
      wait_for_drain();
      program_rotation(16'd0, 16'd16384, 12'd5, 12'd3, 3'd3);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd2, 12'd4);
      send_pixel(12'd1, 12'd2);
      send_pixel(12'd2, 12'd0);

      // 45 degrees, two box corners, an edge point and the centre
      wait_for_drain();
      program_rotation(16'd11585, 16'd11585, 12'd8, 12'd8, 3'd1);
      send_pixel(12'd5, 12'd5);
      send_pixel(12'd0, 12'd11);
      send_pixel(12'd11, 12'd11);
      send_pixel(12'd6, 12'd0);

      // half turn
      wait_for_drain();
      program_rotation(16'hC000, 16'd0, 12'd6, 12'd4, 3'd2);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd5, 12'd3);

      // most negative cosine, oversized width, saturated box, odd channel count
      wait_for_drain();
      program_rotation(16'h8000, 16'h7FFF, 12'd4095, 12'd2048, 3'd7);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd2048, 12'd1024);
      send_pixel(12'd4095, 12'd0);

      // zero source width with no channels
      wait_for_drain();
      program_rotation(16'd0, 16'd16384, 12'd0, 12'd7, 3'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd3, 12'd0);

      // unnormalised factors on a full-width single row
      wait_for_drain();
      program_rotation(16'h7FFF, 16'h8000, 12'd2048, 12'd1, 3'd5);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1024, 12'd2048);

      // random part: three idling profiles, new rotation per block
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               recv_stall_pct = 60;
            end
            1: begin
               send_idle_pct = 60;
               recv_stall_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            wait_for_drain();
            random_rotation();
            repeat (BLOCK_ITEMS) begin
               if ($urandom_range(4) == 0) begin
                  x = 12'($urandom);
                  y = 12'($urandom);
               end else begin
                  x = 12'($urandom_range(0, dest_span));
                  y = 12'($urandom_range(0, dest_span));
               end
               send_pixel(x, y);
            end
         end
      end

      wait_for_drain();
      if (mismatch_count == 0 && pending_count == 0)
         $display("rotate_nearest_address_gen_tb: PASS");
      else
         $display("rotate_nearest_address_gen_tb: FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/rnag_pkg.sv
rtl/core/rnag_if.sv
rtl/core/rnag_flow.sv
rtl/core/rotate_nearest_address_gen.sv
rtl/core/rnag_checker.sv
dv/rotation_map_checker.sv
dv/rotate_nearest_address_gen_tb.sv
